FILE: sv/placement_rect_resolver_core_macros.svh
// ----------------------------------------------------------------------------
// Placement rect resolver assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PLACEMENT_RECT_RESOLVER_CORE_MACROS_SVH
`define PLACEMENT_RECT_RESOLVER_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define PRR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("placement rect resolver check failed");

// Next-cycle implication, ignored while reset is asserted.
`define PRR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("placement rect resolver check failed");

// Next-cycle implication that is also checked across reset.
`define PRR_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("placement rect resolver reset check failed");

`endif

FILE: sv/prr_pkg.sv
// ----------------------------------------------------------------------------
// Placement rect resolver package
// Shared widths, codes and the control struct passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package prr_pkg;

  localparam int PRR_FRAC_BITS_DEF = 16;
  localparam int VAL_W  = 32;
  localparam int DIM_W  = 14;
  localparam int SRC_W  = 14;
  localparam int SIZE_W = 16;
  localparam int POS_W  = 18;
  localparam int KIND_W = 2;
  localparam int MODE_W = 2;
  localparam int ANC_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  // Divider: 16 quotient bits, a few restoring steps per stage.
  localparam int Q_W        = SIZE_W;
  localparam int D_W        = SRC_W + 1;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = Q_W / DIV_STEPS;

  localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

  localparam logic [KIND_W-1:0] KIND_ABSENT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FRAC   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PIX    = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FIT     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FILL    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STRETCH = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NATIVE  = 2'd3;

  localparam logic [ANC_W-1:0] ANC_CENTER    = 4'd0;
  localparam logic [ANC_W-1:0] ANC_TOP_LEFT  = 4'd1;
  localparam logic [ANC_W-1:0] ANC_TOP       = 4'd2;
  localparam logic [ANC_W-1:0] ANC_TOP_RIGHT = 4'd3;
  localparam logic [ANC_W-1:0] ANC_LEFT      = 4'd4;
  localparam logic [ANC_W-1:0] ANC_RIGHT     = 4'd5;
  localparam logic [ANC_W-1:0] ANC_BOT_LEFT  = 4'd6;
  localparam logic [ANC_W-1:0] ANC_BOTTOM    = 4'd7;
  localparam logic [ANC_W-1:0] ANC_BOT_RIGHT = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_DISP_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_H = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ASPECT = 2'd3;

  localparam logic [DIM_W-1:0] DISP_W_RST = 14'd1920;
  localparam logic [DIM_W-1:0] DISP_H_RST = 14'd1080;

  typedef struct packed {
    logic use_div;   // one axis comes from the divider
    logic div_is_h;  // that axis is the height
    logic sat;       // quotient would exceed the size range
  } prr_sel_t;

endpackage

`default_nettype wire

FILE: sv/prr_front.sv
// ----------------------------------------------------------------------------
// Placement rect resolver length front end
// Converts the four lengths to whole pixels over two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module prr_front #(
  parameter int FRAC_BITS = prr_pkg::PRR_FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         v_i,
  input  wire logic [prr_pkg::VAL_W-1:0]    px_val,
  input  wire logic [prr_pkg::KIND_W-1:0]   px_kind,
  input  wire logic [prr_pkg::VAL_W-1:0]    py_val,
  input  wire logic [prr_pkg::KIND_W-1:0]   py_kind,
  input  wire logic [prr_pkg::VAL_W-1:0]    sw_val,
  input  wire logic [prr_pkg::KIND_W-1:0]   sw_kind,
  input  wire logic [prr_pkg::VAL_W-1:0]    sh_val,
  input  wire logic [prr_pkg::KIND_W-1:0]   sh_kind,
  input  wire logic [prr_pkg::SRC_W-1:0]    src_w,
  input  wire logic [prr_pkg::SRC_W-1:0]    src_h,
  input  wire logic [prr_pkg::DIM_W-1:0]    disp_w,
  input  wire logic [prr_pkg::DIM_W-1:0]    disp_h,
  input  wire logic [prr_pkg::MODE_W-1:0]   aspect,
  output logic                              v_o,
  output logic [47-FRAC_BITS-1:0]           ax_o,
  output logic [47-FRAC_BITS-1:0]           ay_o,
  output logic [47-FRAC_BITS-1:0]           bw_o,
  output logic [47-FRAC_BITS-1:0]           bh_o,
  output logic [prr_pkg::SRC_W-1:0]         src_w_o,
  output logic [prr_pkg::SRC_W-1:0]         src_h_o,
  output logic [prr_pkg::MODE_W-1:0]        mode_o
);
  import prr_pkg::*;

  localparam int LEN_W  = 47 - FRAC_BITS;
  localparam int PROD_W = VAL_W + DIM_W;

  logic                v1_r;
  logic [VAL_W-1:0]    val_r  [4];
  logic [KIND_W-1:0]   kind_r [4];
  logic [PROD_W-1:0]   prod_r [4];
  logic [SRC_W-1:0]    sw1_r, sh1_r;

  logic [LEN_W-1:0]    ax_nxt, ay_nxt, bw_nxt, bh_nxt;
  logic [LEN_W-1:0]    bw_raw, bh_raw;

  // Stage 1: fraction products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r[0]  <= px_val;
      val_r[1]  <= py_val;
      val_r[2]  <= sw_val;
      val_r[3]  <= sh_val;
      kind_r[0] <= px_kind;
      kind_r[1] <= py_kind;
      kind_r[2] <= sw_kind;
      kind_r[3] <= sh_kind;
      prod_r[0] <= PROD_W'(px_val) * PROD_W'(disp_w);
      prod_r[1] <= PROD_W'(py_val) * PROD_W'(disp_h);
      prod_r[2] <= PROD_W'(sw_val) * PROD_W'(disp_w);
      prod_r[3] <= PROD_W'(sh_val) * PROD_W'(disp_h);
      sw1_r     <= src_w;
      sh1_r     <= src_h;
    end
  end

  function automatic logic [LEN_W-1:0] to_px(
    input logic [VAL_W-1:0]  v,
    input logic [PROD_W-1:0] p,
    input logic [KIND_W-1:0] k,
    input logic [LEN_W-1:0]  dflt
  );
    logic [PROD_W-1:0] half;
    logic [PROD_W-1:0] s_pix;
    logic [PROD_W-1:0] s_frac;
    logic [LEN_W-1:0]  res;
    begin
      half   = PROD_W'(1) << (FRAC_BITS - 1);
      s_pix  = (PROD_W'(v) + half) >> FRAC_BITS;
      s_frac = (p + half) >> FRAC_BITS;
      unique case (k)
        KIND_PIX:  res = s_pix[LEN_W-1:0];
        KIND_FRAC: res = s_frac[LEN_W-1:0];
        default:   res = dflt;
      endcase
      to_px = res;
    end
  endfunction

  // Stage 2: rounding to pixels and defaults.
  always_comb begin
    ax_nxt = to_px(val_r[0], prod_r[0], kind_r[0], LEN_W'(disp_w >> 1));
    ay_nxt = to_px(val_r[1], prod_r[1], kind_r[1], LEN_W'(disp_h >> 1));
    bw_raw = to_px(val_r[2], prod_r[2], kind_r[2], LEN_W'(disp_w));
    bh_raw = to_px(val_r[3], prod_r[3], kind_r[3], LEN_W'(disp_h));
    bw_nxt = (bw_raw == '0) ? LEN_W'(1) : bw_raw;
    bh_nxt = (bh_raw == '0) ? LEN_W'(1) : bh_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_o    <= ax_nxt;
      ay_o    <= ay_nxt;
      bw_o    <= bw_nxt;
      bh_o    <= bh_nxt;
      src_w_o <= sw1_r;
      src_h_o <= sh1_r;
      // An unknown source dimension forces stretch.
      mode_o  <= (sw1_r == '0 || sh1_r == '0) ? MODE_STRETCH : aspect;
    end
  end

endmodule

`default_nettype wire

FILE: sv/prr_ratio.sv
// ----------------------------------------------------------------------------
// Placement rect resolver aspect stage
// Cross-multiplies bounds and source size, picks the tight axis and sets up
// the division for the free axis.
// ----------------------------------------------------------------------------
`default_nettype none

module prr_ratio #(
  parameter int FRAC_BITS = prr_pkg::PRR_FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         v_i,
  input  wire logic [47-FRAC_BITS-1:0]      ax_i,
  input  wire logic [47-FRAC_BITS-1:0]      ay_i,
  input  wire logic [47-FRAC_BITS-1:0]      bw_i,
  input  wire logic [47-FRAC_BITS-1:0]      bh_i,
  input  wire logic [prr_pkg::SRC_W-1:0]    src_w_i,
  input  wire logic [prr_pkg::SRC_W-1:0]    src_h_i,
  input  wire logic [prr_pkg::MODE_W-1:0]   mode_i,
  output logic                              v_o,
  output prr_pkg::prr_sel_t                 sel_o,
  output logic [prr_pkg::Q_W-1:0]           nlo_o,
  output logic [prr_pkg::D_W-1:0]           rem_o,
  output logic [prr_pkg::D_W-1:0]           den_o,
  output logic [prr_pkg::SIZE_W-1:0]        wfix_o,
  output logic [prr_pkg::SIZE_W-1:0]        hfix_o,
  output logic [47-FRAC_BITS-1:0]           ax_o,
  output logic [47-FRAC_BITS-1:0]           ay_o
);
  import prr_pkg::*;

  localparam int LEN_W = 47 - FRAC_BITS;
  localparam int MUL_W = LEN_W + SRC_W;
  localparam int NUM_W = MUL_W + 2;

  logic               v3_r;
  logic [MUL_W-1:0]   lhs_r, rhs_r;
  logic [LEN_W-1:0]   bw3_r, bh3_r, ax3_r, ay3_r;
  logic [SRC_W-1:0]   sw3_r, sh3_r;
  logic [MODE_W-1:0]  mode3_r;

  logic               tight_w;
  logic [NUM_W-1:0]   num;
  logic [D_W-1:0]     den;
  prr_sel_t           sel_nxt;
  logic [SIZE_W-1:0]  wfix_nxt, hfix_nxt;

  // Stage 3: bw*sh and bh*sw.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lhs_r   <= MUL_W'(bw_i) * MUL_W'(src_h_i);
      rhs_r   <= MUL_W'(bh_i) * MUL_W'(src_w_i);
      bw3_r   <= bw_i;
      bh3_r   <= bh_i;
      ax3_r   <= ax_i;
      ay3_r   <= ay_i;
      sw3_r   <= src_w_i;
      sh3_r   <= src_h_i;
      mode3_r <= mode_i;
    end
  end

  function automatic logic [SIZE_W-1:0] sat_len(input logic [LEN_W-1:0] x);
    begin
      if (x > LEN_W'(SIZE_MAX)) begin
        sat_len = SIZE_MAX;
      end else if (x == '0) begin
        sat_len = SIZE_W'(1);
      end else begin
        sat_len = x[SIZE_W-1:0];
      end
    end
  endfunction

  // Stage 4: the free axis is round(s*bound / s'), as (2*s*bound + s') / (2*s').
  always_comb begin
    tight_w = (mode3_r == MODE_FIT) ? (lhs_r < rhs_r) : (lhs_r > rhs_r);
    if (tight_w) begin
      num = {1'b0, lhs_r, 1'b0} + NUM_W'(sw3_r);
      den = {sw3_r, 1'b0};
    end else begin
      num = {1'b0, rhs_r, 1'b0} + NUM_W'(sh3_r);
      den = {sh3_r, 1'b0};
    end
    sel_nxt.sat = num >= (NUM_W'(den) << Q_W);
    unique case (mode3_r)
      MODE_NATIVE: begin
        sel_nxt.use_div  = 1'b0;
        sel_nxt.div_is_h = 1'b0;
        wfix_nxt         = SIZE_W'(sw3_r);
        hfix_nxt         = SIZE_W'(sh3_r);
      end
      MODE_STRETCH: begin
        sel_nxt.use_div  = 1'b0;
        sel_nxt.div_is_h = 1'b0;
        wfix_nxt         = sat_len(bw3_r);
        hfix_nxt         = sat_len(bh3_r);
      end
      default: begin
        sel_nxt.use_div  = 1'b1;
        sel_nxt.div_is_h = tight_w;
        wfix_nxt         = sat_len(bw3_r);
        hfix_nxt         = sat_len(bh3_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_o  <= sel_nxt;
      nlo_o  <= num[Q_W-1:0];
      rem_o  <= num[Q_W +: D_W];
      den_o  <= den;
      wfix_o <= wfix_nxt;
      hfix_o <= hfix_nxt;
      ax_o   <= ax3_r;
      ay_o   <= ay3_r;
    end
  end

endmodule

`default_nettype wire

FILE: sv/prr_div.sv
// ----------------------------------------------------------------------------
// Placement rect resolver divider
// Pipelined restoring divider producing a 16-bit quotient, a few bits per
// stage, with the placement data carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module prr_div #(
  parameter int FRAC_BITS = prr_pkg::PRR_FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         v_i,
  input  wire prr_pkg::prr_sel_t            sel_i,
  input  wire logic [prr_pkg::Q_W-1:0]      nlo_i,
  input  wire logic [prr_pkg::D_W-1:0]      rem_i,
  input  wire logic [prr_pkg::D_W-1:0]      den_i,
  input  wire logic [prr_pkg::SIZE_W-1:0]   wfix_i,
  input  wire logic [prr_pkg::SIZE_W-1:0]   hfix_i,
  input  wire logic [47-FRAC_BITS-1:0]      ax_i,
  input  wire logic [47-FRAC_BITS-1:0]      ay_i,
  output logic                              v_o,
  output prr_pkg::prr_sel_t                 sel_o,
  output logic [prr_pkg::Q_W-1:0]           quo_o,
  output logic [prr_pkg::SIZE_W-1:0]        wfix_o,
  output logic [prr_pkg::SIZE_W-1:0]        hfix_o,
  output logic [47-FRAC_BITS-1:0]           ax_o,
  output logic [47-FRAC_BITS-1:0]           ay_o
);
  import prr_pkg::*;

  localparam int LEN_W = 47 - FRAC_BITS;

  typedef struct packed {
    logic [D_W-1:0] rem;
    logic [Q_W-1:0] nb;
    logic [Q_W-1:0] q;
  } div_st_t;

  logic [DIV_STAGES-1:0] v_r;
  div_st_t               st_r   [DIV_STAGES];
  logic [D_W-1:0]        den_r  [DIV_STAGES];
  prr_sel_t              sel_r  [DIV_STAGES];
  logic [SIZE_W-1:0]     wfix_r [DIV_STAGES];
  logic [SIZE_W-1:0]     hfix_r [DIV_STAGES];
  logic [LEN_W-1:0]      ax_r   [DIV_STAGES];
  logic [LEN_W-1:0]      ay_r   [DIV_STAGES];

  div_st_t               st_src  [DIV_STAGES];
  logic [D_W-1:0]        den_src [DIV_STAGES];

  function automatic div_st_t div_steps(input div_st_t s, input logic [D_W-1:0] d);
    logic [D_W:0] t;
    div_st_t      o;
    begin
      o = s;
      for (int i = 0; i < DIV_STEPS; i++) begin
        t    = {o.rem, o.nb[Q_W-1]};
        o.nb = {o.nb[Q_W-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
          o.rem = D_W'(t - {1'b0, d});
          o.q   = {o.q[Q_W-2:0], 1'b1};
        end else begin
          o.rem = t[D_W-1:0];
          o.q   = {o.q[Q_W-2:0], 1'b0};
        end
      end
      div_steps = o;
    end
  endfunction

  always_comb begin
    st_src[0].rem = rem_i;
    st_src[0].nb  = nlo_i;
    st_src[0].q   = '0;
    den_src[0]    = den_i;
    for (int k = 1; k < DIV_STAGES; k++) begin
      st_src[k]  = st_r[k-1];
      den_src[k] = den_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DIV_STAGES-2:0], v_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        st_r[k]  <= div_steps(st_src[k], den_src[k]);
        den_r[k] <= den_src[k];
      end
      sel_r[0]  <= sel_i;
      wfix_r[0] <= wfix_i;
      hfix_r[0] <= hfix_i;
      ax_r[0]   <= ax_i;
      ay_r[0]   <= ay_i;
      for (int k = 1; k < DIV_STAGES; k++) begin
        sel_r[k]  <= sel_r[k-1];
        wfix_r[k] <= wfix_r[k-1];
        hfix_r[k] <= hfix_r[k-1];
        ax_r[k]   <= ax_r[k-1];
        ay_r[k]   <= ay_r[k-1];
      end
    end
  end

  assign v_o    = v_r[DIV_STAGES-1];
  assign sel_o  = sel_r[DIV_STAGES-1];
  assign quo_o  = st_r[DIV_STAGES-1].q;
  assign wfix_o = wfix_r[DIV_STAGES-1];
  assign hfix_o = hfix_r[DIV_STAGES-1];
  assign ax_o   = ax_r[DIV_STAGES-1];
  assign ay_o   = ay_r[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: sv/placement_rect_resolver_core.sv
// ----------------------------------------------------------------------------
// Placement rect resolver core
// Resolves an anchored, aspect-shaped rectangle on the display per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (in_valid/in_ready) carry four Q-format lengths with kind
//   codes plus the source size. Each request yields one result on the
//   out_valid/out_ready channel with the placed rectangle.
//   The cfg channel writes display width, display height, anchor point and
//   aspect mode by index; cfg_ready is always high. Write it only while no
//   request is in flight.
//   From acceptance to out_valid a request passes two stages of length
//   conversion, two of cross-multiply and setup, four divider stages of
//   four quotient bits each, and the output register. Throughput is one
//   request per cycle while no result is held; the divider is fully pipelined.
//   When out_ready is low while a result is shown, the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated.
//   Reset clears all valid bits and loads the display 1920x1080, center
//   anchor and fit mode.
// ----------------------------------------------------------------------------
`default_nettype none

module placement_rect_resolver_core #(
  parameter int FRAC_BITS = prr_pkg::PRR_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [prr_pkg::VAL_W-1:0]         in_pos_x_value,
  input  wire logic [prr_pkg::KIND_W-1:0]        in_pos_x_kind,
  input  wire logic [prr_pkg::VAL_W-1:0]         in_pos_y_value,
  input  wire logic [prr_pkg::KIND_W-1:0]        in_pos_y_kind,
  input  wire logic [prr_pkg::VAL_W-1:0]         in_size_w_value,
  input  wire logic [prr_pkg::KIND_W-1:0]        in_size_w_kind,
  input  wire logic [prr_pkg::VAL_W-1:0]         in_size_h_value,
  input  wire logic [prr_pkg::KIND_W-1:0]        in_size_h_kind,
  input  wire logic [prr_pkg::SRC_W-1:0]         in_source_width,
  input  wire logic [prr_pkg::SRC_W-1:0]         in_source_height,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [prr_pkg::POS_W-1:0]       out_rect_left,
  output logic signed [prr_pkg::POS_W-1:0]       out_rect_top,
  output logic [prr_pkg::SIZE_W-1:0]             out_rect_width,
  output logic [prr_pkg::SIZE_W-1:0]             out_rect_height,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [prr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [prr_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import prr_pkg::*;

  localparam int LEN_W  = 47 - FRAC_BITS;
  localparam int DIFF_W = LEN_W + 1;
  localparam logic signed [DIFF_W-1:0] POS_LO = -(DIFF_W'(1) << (POS_W - 1));
  localparam logic signed [DIFF_W-1:0] POS_HI = (DIFF_W'(1) << (POS_W - 1)) - DIFF_W'(1);

  logic [DIM_W-1:0]  disp_w_r, disp_h_r;
  logic [ANC_W-1:0]  anchor_r;
  logic [MODE_W-1:0] aspect_r;

  logic en;

  logic              f_v;
  logic [LEN_W-1:0]  f_ax, f_ay, f_bw, f_bh;
  logic [SRC_W-1:0]  f_sw, f_sh;
  logic [MODE_W-1:0] f_mode;

  logic              r_v;
  prr_sel_t          r_sel;
  logic [Q_W-1:0]    r_nlo;
  logic [D_W-1:0]    r_rem, r_den;
  logic [SIZE_W-1:0] r_wfix, r_hfix;
  logic [LEN_W-1:0]  r_ax, r_ay;

  logic              d_v;
  prr_sel_t          d_sel;
  logic [Q_W-1:0]    d_quo;
  logic [SIZE_W-1:0] d_wfix, d_hfix;
  logic [LEN_W-1:0]  d_ax, d_ay;

  logic [SIZE_W-1:0] q_fix, w_nxt, h_nxt, dx, dy;
  logic signed [DIFF_W-1:0] lx, ty;
  logic signed [POS_W-1:0]  left_nxt, top_nxt;

  logic                     out_valid_r;
  logic signed [POS_W-1:0]  left_r, top_r;
  logic [SIZE_W-1:0]        width_r, height_r;

  // The whole pipeline advances unless a shown result is being held.
  assign en        = out_ready || !out_valid_r;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_w_r <= DISP_W_RST;
      disp_h_r <= DISP_H_RST;
      anchor_r <= ANC_CENTER;
      aspect_r <= MODE_FIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DISP_W: disp_w_r <= cfg_data;
        CFG_DISP_H: disp_h_r <= cfg_data;
        CFG_ANCHOR: anchor_r <= cfg_data[ANC_W-1:0];
        CFG_ASPECT: aspect_r <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  prr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_i     (in_valid && en),
    .px_val  (in_pos_x_value),
    .px_kind (in_pos_x_kind),
    .py_val  (in_pos_y_value),
    .py_kind (in_pos_y_kind),
    .sw_val  (in_size_w_value),
    .sw_kind (in_size_w_kind),
    .sh_val  (in_size_h_value),
    .sh_kind (in_size_h_kind),
    .src_w   (in_source_width),
    .src_h   (in_source_height),
    .disp_w  (disp_w_r),
    .disp_h  (disp_h_r),
    .aspect  (aspect_r),
    .v_o     (f_v),
    .ax_o    (f_ax),
    .ay_o    (f_ay),
    .bw_o    (f_bw),
    .bh_o    (f_bh),
    .src_w_o (f_sw),
    .src_h_o (f_sh),
    .mode_o  (f_mode)
  );

  prr_ratio #(.FRAC_BITS(FRAC_BITS)) u_ratio (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_i     (f_v),
    .ax_i    (f_ax),
    .ay_i    (f_ay),
    .bw_i    (f_bw),
    .bh_i    (f_bh),
    .src_w_i (f_sw),
    .src_h_i (f_sh),
    .mode_i  (f_mode),
    .v_o     (r_v),
    .sel_o   (r_sel),
    .nlo_o   (r_nlo),
    .rem_o   (r_rem),
    .den_o   (r_den),
    .wfix_o  (r_wfix),
    .hfix_o  (r_hfix),
    .ax_o    (r_ax),
    .ay_o    (r_ay)
  );

  prr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (r_v),
    .sel_i  (r_sel),
    .nlo_i  (r_nlo),
    .rem_i  (r_rem),
    .den_i  (r_den),
    .wfix_i (r_wfix),
    .hfix_i (r_hfix),
    .ax_i   (r_ax),
    .ay_i   (r_ay),
    .v_o    (d_v),
    .sel_o  (d_sel),
    .quo_o  (d_quo),
    .wfix_o (d_wfix),
    .hfix_o (d_hfix),
    .ax_o   (d_ax),
    .ay_o   (d_ay)
  );

  always_comb begin
    if (d_sel.sat) begin
      q_fix = SIZE_MAX;
    end else if (d_quo == '0) begin
      q_fix = SIZE_W'(1);
    end else begin
      q_fix = d_quo;
    end
    w_nxt = (d_sel.use_div && !d_sel.div_is_h) ? q_fix : d_wfix;
    h_nxt = (d_sel.use_div && d_sel.div_is_h) ? q_fix : d_hfix;

    unique case (anchor_r)
      ANC_TOP_LEFT:  begin dx = '0;         dy = '0;         end
      ANC_TOP:       begin dx = w_nxt >> 1; dy = '0;         end
      ANC_TOP_RIGHT: begin dx = w_nxt;      dy = '0;         end
      ANC_LEFT:      begin dx = '0;         dy = h_nxt >> 1; end
      ANC_RIGHT:     begin dx = w_nxt;      dy = h_nxt >> 1; end
      ANC_BOT_LEFT:  begin dx = '0;         dy = h_nxt;      end
      ANC_BOTTOM:    begin dx = w_nxt >> 1; dy = h_nxt;      end
      ANC_BOT_RIGHT: begin dx = w_nxt;      dy = h_nxt;      end
      default:       begin dx = w_nxt >> 1; dy = h_nxt >> 1; end
    endcase

    lx = $signed({1'b0, d_ax}) - $signed(DIFF_W'(dx));
    ty = $signed({1'b0, d_ay}) - $signed(DIFF_W'(dy));

    if (lx < POS_LO) begin
      left_nxt = POS_LO[POS_W-1:0];
    end else if (lx > POS_HI) begin
      left_nxt = POS_HI[POS_W-1:0];
    end else begin
      left_nxt = lx[POS_W-1:0];
    end
    if (ty < POS_LO) begin
      top_nxt = POS_LO[POS_W-1:0];
    end else if (ty > POS_HI) begin
      top_nxt = POS_HI[POS_W-1:0];
    end else begin
      top_nxt = ty[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      left_r   <= left_nxt;
      top_r    <= top_nxt;
      width_r  <= w_nxt;
      height_r <= h_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rect_left   = left_r;
  assign out_rect_top    = top_r;
  assign out_rect_width  = width_r;
  assign out_rect_height = height_r;

endmodule

`default_nettype wire

FILE: sv/prr_checker.sv
// ----------------------------------------------------------------------------
// Placement rect resolver port checker
// Watches the top-level ports for stall, reset and result sanity rules.
// ----------------------------------------------------------------------------
`default_nettype none

`include "placement_rect_resolver_core_macros.svh"

module prr_checker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  input  wire logic                              in_ready,
  input  wire logic                              out_valid,
  input  wire logic                              out_ready,
  input  wire logic signed [prr_pkg::POS_W-1:0]  out_rect_left,
  input  wire logic signed [prr_pkg::POS_W-1:0]  out_rect_top,
  input  wire logic [prr_pkg::SIZE_W-1:0]        out_rect_width,
  input  wire logic [prr_pkg::SIZE_W-1:0]        out_rect_height,
  input  wire logic                              cfg_ready
);

  // A held result keeps its payload.
  `PRR_ASSERT_NXT(a_hold, out_valid && !out_ready,
    out_valid && $stable(out_rect_left) && $stable(out_rect_top) && $stable(out_rect_width) && $stable(out_rect_height))

  // A stalled output stops new requests.
  `PRR_ASSERT_IMP(a_stall, out_valid && !out_ready, !in_ready)

  // Placed sizes are never zero.
  `PRR_ASSERT_IMP(a_size, out_valid, out_rect_width != '0 && out_rect_height != '0 && cfg_ready)

  // Nothing comes out right after reset.
  `PRR_ASSERT_RST(a_reset, !rst_n, !out_valid)

endmodule

bind placement_rect_resolver_core prr_checker u_prr_checker (.*);

`default_nettype wire
